// ----- design/assert_macros.svh -----
// assertion macros shared by the stream find-and-replace modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// combinational check, sampled on every rising clock edge outside reset
`define SFR_ASSERT(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error(msg);

// same-cycle implication
`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SFR_ASSERT(lbl, clk, rst_n, expr, msg)
`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/sfr_pkg.sv -----
// shared types, constants and helpers of the stream find-and-replace block
package sfr_pkg;

	localparam int MAX_STR_LEN = 8;
	localparam int REG_BYTES   = 8;
	localparam int LEN_LIMIT   = (MAX_STR_LEN < REG_BYTES) ? MAX_STR_LEN : REG_BYTES;
	localparam int LEN_W       = $clog2(LEN_LIMIT + 1);
	localparam int POS_W       = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;
	localparam int CFG_LEN_W   = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;

	typedef logic [7:0] byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLEN   = 2'd0,
		REG_PBYTES = 2'd1,
		REG_RLEN   = 2'd2,
		REG_RBYTES = 2'd3
	} cfg_reg_t;

	// effective configuration as the datapath sees it
	typedef struct packed {
		logic [LEN_W-1:0]            plen;
		byte_t [LEN_LIMIT-1:0]       pbytes;
		logic [LEN_W-1:0]            rlen;
		byte_t [LEN_LIMIT-1:0]       rbytes;
	} cfg_t;

	// results caused by one item, head at entry 0
	typedef struct packed {
		byte_t [LEN_LIMIT-1:0] data;
		logic [LEN_W-1:0]      cnt;
		logic                  mark;
		logic                  bare;
	} burst_t;

	// pattern length: zero acts as one, clipped at the limit
	function automatic logic [LEN_W-1:0] eff_plen(input logic [CFG_LEN_W-1:0] raw);
		logic [LEN_W-1:0] res;
		if (raw == '0) begin
			res = LEN_W'(1);
		end else if (int'(raw) > LEN_LIMIT) begin
			res = LEN_W'(LEN_LIMIT);
		end else begin
			res = LEN_W'(raw);
		end
		return res;
	endfunction

	// replacement length: clipped at the limit
	function automatic logic [LEN_W-1:0] eff_rlen(input logic [CFG_LEN_W-1:0] raw);
		logic [LEN_W-1:0] res;
		if (int'(raw) > LEN_LIMIT) begin
			res = LEN_W'(LEN_LIMIT);
		end else begin
			res = LEN_W'(raw);
		end
		return res;
	endfunction

endpackage

// ----- design/sfr_cfg.sv -----
// configuration registers of the stream find-and-replace block
module sfr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sfr_pkg::cfg_t                    cfg,
	output logic                             win_clr
);

	sfr_pkg::cfg_t cfg_q;
	logic          wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plen   <= sfr_pkg::LEN_W'(1);
			cfg_q.pbytes <= '0;
			cfg_q.rlen   <= '0;
			cfg_q.rbytes <= '0;
		end else if (wr) begin
			case (sfr_pkg::cfg_reg_t'(cfg_index))
				sfr_pkg::REG_PLEN: begin
					cfg_q.plen <= sfr_pkg::eff_plen(cfg_data[sfr_pkg::CFG_LEN_W-1:0]);
				end
				sfr_pkg::REG_PBYTES: begin
					cfg_q.pbytes <= cfg_data[8*sfr_pkg::LEN_LIMIT-1:0];
				end
				sfr_pkg::REG_RLEN: begin
					cfg_q.rlen <= sfr_pkg::eff_rlen(cfg_data[sfr_pkg::CFG_LEN_W-1:0]);
				end
				sfr_pkg::REG_RBYTES: begin
					cfg_q.rbytes <= cfg_data[8*sfr_pkg::LEN_LIMIT-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// a new pattern discards whatever waits in the window
	assign win_clr = wr && ((sfr_pkg::cfg_reg_t'(cfg_index) == sfr_pkg::REG_PLEN) ||
		(sfr_pkg::cfg_reg_t'(cfg_index) == sfr_pkg::REG_PBYTES));

	assign cfg = cfg_q;

endmodule

// ----- design/sfr_core.sv -----
// match window: holds pending bytes, tests the pattern, builds the result burst
`include "assert_macros.svh"

module sfr_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfr_pkg::cfg_t         cfg,
	input  logic                  win_clr,
	input  logic                  take,
	input  sfr_pkg::byte_t        in_byte,
	input  logic                  in_last,
	output sfr_pkg::burst_t       burst
);

	sfr_pkg::byte_t [sfr_pkg::LEN_LIMIT-1:0] win_q;
	logic [sfr_pkg::POS_W-1:0]               wcnt_q;

	sfr_pkg::byte_t [sfr_pkg::LEN_LIMIT-1:0] wn;
	sfr_pkg::byte_t [sfr_pkg::LEN_LIMIT-1:0] win_d;
	logic [sfr_pkg::LEN_W-1:0]               fill;
	logic [sfr_pkg::LEN_LIMIT-1:0]           hit;
	logic                                    full;
	logic                                    match;
	logic [sfr_pkg::POS_W-1:0]               wcnt_d;

	always_comb begin
		wn = win_q;
		wn[wcnt_q] = in_byte;
		fill = sfr_pkg::LEN_W'(wcnt_q) + sfr_pkg::LEN_W'(1);
		full = (fill == cfg.plen);
		for (int k = 0; k < sfr_pkg::LEN_LIMIT; k++) begin
			hit[k] = (sfr_pkg::LEN_W'(k) >= cfg.plen) || (wn[k] == cfg.pbytes[k]);
		end
		match = full && (&hit);
	end

	// results of this item
	always_comb begin
		burst.mark = in_last;
		burst.bare = 1'b0;
		if (match) begin
			burst.data = cfg.rbytes;
			burst.cnt  = cfg.rlen;
		end else begin
			burst.data = wn;
			if (in_last) begin
				burst.cnt = fill;
			end else if (full) begin
				burst.cnt = sfr_pkg::LEN_W'(1);
			end else begin
				burst.cnt = '0;
			end
		end
		if (in_last && (burst.cnt == '0)) begin
			burst.bare    = 1'b1;
			burst.cnt     = sfr_pkg::LEN_W'(1);
			burst.data[0] = '0;
		end
	end

	// next window contents and fill
	always_comb begin
		if (full) begin
			for (int k = 0; k < sfr_pkg::LEN_LIMIT - 1; k++) begin
				win_d[k] = wn[k+1];
			end
			win_d[sfr_pkg::LEN_LIMIT-1] = wn[sfr_pkg::LEN_LIMIT-1];
		end else begin
			win_d = wn;
		end
		if (match || in_last) begin
			wcnt_d = '0;
		end else if (full) begin
			wcnt_d = sfr_pkg::POS_W'(cfg.plen - sfr_pkg::LEN_W'(1));
		end else begin
			wcnt_d = sfr_pkg::POS_W'(fill);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			win_q <= win_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
		end else if (win_clr) begin
			wcnt_q <= '0;
		end else if (take) begin
			wcnt_q <= wcnt_d;
		end
	end

	// the window never holds a whole pattern between items
	`SFR_ASSERT(a_wcnt_below_plen, clk, arst_n, sfr_pkg::LEN_W'(wcnt_q) < cfg.plen, "window fill reached pattern length")

endmodule

// ----- design/sfr_emit.sv -----
// result burst buffer and output register
`include "assert_macros.svh"

module sfr_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  sfr_pkg::burst_t   burst,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output sfr_pkg::byte_t    out_byte,
	output logic              has_byte,
	output logic              out_last
);

	sfr_pkg::byte_t [sfr_pkg::LEN_LIMIT-1:0] data_s1;
	logic [sfr_pkg::LEN_W-1:0]               cnt_s1;
	logic                                    mark_s1;
	logic                                    bare_s1;

	logic           out_valid_q;
	sfr_pkg::byte_t out_byte_q;
	logic           has_byte_q;
	logic           out_last_q;

	logic move;

	assign move     = (cnt_s1 != '0) && (!out_valid_q || out_ready);
	assign in_ready = (cnt_s1 == '0) || ((cnt_s1 == sfr_pkg::LEN_W'(1)) && move);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (take) begin
			cnt_s1 <= burst.cnt;
		end else if (move) begin
			cnt_s1 <= cnt_s1 - sfr_pkg::LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= burst.data;
			mark_s1 <= burst.mark;
			bare_s1 <= burst.bare;
		end else if (move) begin
			for (int k = 0; k < sfr_pkg::LEN_LIMIT - 1; k++) begin
				data_s1[k] <= data_s1[k+1];
			end
			data_s1[sfr_pkg::LEN_LIMIT-1] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= data_s1[0];
			has_byte_q <= !bare_s1;
			out_last_q <= mark_s1 && (cnt_s1 == sfr_pkg::LEN_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_byte_q;
	assign out_last  = out_last_q;

	`SFR_ASSERT(a_cnt_bound, clk, arst_n, int'(cnt_s1) <= sfr_pkg::LEN_LIMIT, "burst count above limit")
	`SFR_ASSERT_IMP(a_bare_single, clk, arst_n, (cnt_s1 != '0) && bare_s1, (cnt_s1 == sfr_pkg::LEN_W'(1)) && mark_s1, "bare end mark not alone")
	`SFR_ASSERT_IMP(a_bare_is_last, clk, arst_n, out_valid_q && !has_byte_q, out_last_q && (out_byte_q == '0), "bare result without end mark")
	`SFR_ASSERT_NXT(a_move_fills, clk, arst_n, move, out_valid_q, "moved result not presented")

endmodule

// ----- design/stream_find_replace.sv -----
// top level of the streaming find-and-replace block
// an accepted item's results pass the burst buffer and then the output register on their way out
// throughput: one item per cycle while each item causes at most one result and no output stall
// an item with n > 1 results holds the input until the last moves out (one per cycle unless stalled)
// reset: arst_n clears window fill, burst count and output valid; pattern_len goes to 1,
// all other config registers to 0; window bytes and buffered result data are not reset
module stream_find_replace (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input item channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_byte,
	input  logic                            in_last,
	// result item channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic                            has_byte,
	output logic                            out_last
);

	sfr_pkg::cfg_t   cfg;
	sfr_pkg::burst_t burst;
	logic            win_clr;
	logic            take;

	// config registers; a pattern write empties the window
	sfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.win_clr   (win_clr)
	);

	// window update and match happen in the cycle the item is taken;
	// the whole set of results for the item is formed combinationally
	sfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.win_clr (win_clr),
		.take    (take),
		.in_byte (in_byte),
		.in_last (in_last),
		.burst   (burst)
	);

	// burst buffer drains one result per cycle into the output register while the output does not stall;
	// a new item is taken as soon as the buffer's last result moves out
	sfr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last)
	);

endmodule
